FILE: design/cwa_pkg.sv
// shared constants, types and state codes of the circular wrap average block
package cwa_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int PERIOD_W        = 17;
    // one adjusted sample spans -period .. sample + period, signed
    localparam int ADJ_W           = 19;
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd16384;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_NORM
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

FILE: design/cwa_if.sv
// stream interfaces for the sample input and the average output
interface cwa_in_if;
    logic                          valid;
    logic                          ready;
    logic [cwa_pkg::SAMPLE_W-1:0]  sample;
    logic                          last_sample;

    modport source (output valid, sample, last_sample, input ready);
    modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface cwa_out_if;
    logic                          valid;
    logic                          ready;
    logic [cwa_pkg::SAMPLE_W-1:0]  average;
    logic                          overflowed;

    modport source (output valid, average, overflowed, input ready);
    modport sink   (input valid, average, overflowed, output ready);
endinterface

FILE: design/circular_wrap_average.sv
// top level of the circular wrap average block
//
// usage
//   i_smp carries sample beats (sample, last_sample); a beat moves when valid
//   and ready are both high. the first beat of a run sets the reference, each
//   later beat is unwrapped by one period against it and summed. the beat with
//   last_sample set closes the run and produces one beat on o_avg.
//   i_cfg_we / i_cfg_wdata write the wrap period; write only while idle.
// throughput
//   one sample beat per cycle while the run queue is not full; the bit-serial
//   divider works on one queued run at a time and takes the next only when done
// result path
//   a run total goes from the queue through the divide, sign and normalize states to o_avg
// stalls
//   finished run totals wait in a short queue; i_smp.ready drops only when
//   that queue is full. a stalled o_avg beat holds in the output register
//   while the divider already works on the next queued run.
// reset
//   i_rst_n low (synchronous) drops any run in progress, empties the queue
//   and output register and sets the period to 16384
module circular_wrap_average #(
    parameter int MAX_SAMPLES = cwa_pkg::MAX_SAMPLES_DEF,
    parameter int QUEUE_DEPTH = cwa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cwa_pkg::PERIOD_W-1:0]   i_cfg_wdata,
    cwa_in_if.sink                         i_smp,
    cwa_out_if.source                      o_avg
);

    // count holds MAX_SAMPLES itself; sum grows one bit per doubling of capacity
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = cwa_pkg::ADJ_W + $clog2(MAX_SAMPLES);
    localparam int ENT_W = SUM_W + CNT_W + 1;

    logic [cwa_pkg::PERIOD_W-1:0] r_period;
    logic                         push, pop;
    logic [ENT_W-1:0]             push_data, head;
    cwa_pkg::t_q_flags            q_flags;

    // wrap period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= cwa_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    // accumulate one sample per beat up to MAX_SAMPLES, push the run total on the last beat
    cwa_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .ENT_W       (ENT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_period    (r_period),
        .i_smp       (i_smp),
        .i_q_flags   (q_flags),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // decouples the accumulator from the divider
    cwa_queue #(
        .W     (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_flags     (q_flags)
    );

    // divide, normalize into the period, drive the result beat
    cwa_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .ENT_W       (ENT_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_period  (r_period),
        .i_head    (head),
        .i_q_flags (q_flags),
        .o_pop     (pop),
        .o_avg     (o_avg)
    );

endmodule

FILE: design/cwa_front.sv
// front end: takes sample beats, unwraps them against the reference and sums the run
module cwa_front #(
    parameter int MAX_SAMPLES = cwa_pkg::MAX_SAMPLES_DEF,
    parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
    parameter int SUM_W       = cwa_pkg::ADJ_W + $clog2(MAX_SAMPLES),
    parameter int ENT_W       = SUM_W + CNT_W + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [cwa_pkg::PERIOD_W-1:0]   i_period,
    cwa_in_if.sink                         i_smp,
    input  cwa_pkg::t_q_flags              i_q_flags,
    output logic                           o_push,
    output logic [ENT_W-1:0]               o_push_data
);

    localparam int ADJ_W = cwa_pkg::ADJ_W;

    logic [cwa_pkg::SAMPLE_W-1:0] r_ref,     n_ref;
    logic signed [SUM_W-1:0]      r_sum,     n_sum;
    logic [CNT_W-1:0]             r_cnt,     n_cnt;
    logic                         r_started, n_started;
    logic                         r_ovf,     n_ovf;

    logic                         accept;
    logic signed [ADJ_W-1:0]      v_s, delta, half_s, per_s, adj;
    logic signed [SUM_W-1:0]      run_sum;
    logic [CNT_W-1:0]             run_cnt;
    logic                         run_ovf;

    assign i_smp.ready = !i_q_flags.full;
    assign accept      = i_smp.valid && i_smp.ready;

    // unwrap against the reference
    always_comb begin
        v_s    = $signed({3'b000, i_smp.sample});
        delta  = v_s - $signed({3'b000, r_ref});
        half_s = $signed({3'b000, i_period[cwa_pkg::PERIOD_W-1:1]});
        per_s  = $signed({2'b00, i_period});
        if (delta > half_s) begin
            adj = v_s - per_s;
        end else if (delta < -half_s) begin
            adj = v_s + per_s;
        end else begin
            adj = v_s;
        end
    end

    // run state after this beat
    always_comb begin
        run_sum = r_sum;
        run_cnt = r_cnt;
        run_ovf = r_ovf;
        if (!r_started) begin
            run_sum = $signed(SUM_W'(i_smp.sample));
            run_cnt = CNT_W'(1);
        end else if (r_cnt < CNT_W'(MAX_SAMPLES)) begin
            run_sum = r_sum + SUM_W'(adj);
            run_cnt = r_cnt + CNT_W'(1);
        end else begin
            run_ovf = 1'b1;
        end
    end

    always_comb begin
        n_ref     = r_ref;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_started = r_started;
        n_ovf     = r_ovf;
        if (accept) begin
            if (i_smp.last_sample) begin
                n_ref     = '0;
                n_sum     = '0;
                n_cnt     = '0;
                n_started = 1'b0;
                n_ovf     = 1'b0;
            end else begin
                if (!r_started) begin
                    n_ref = i_smp.sample;
                end
                n_sum     = run_sum;
                n_cnt     = run_cnt;
                n_started = 1'b1;
                n_ovf     = run_ovf;
            end
        end
    end

    assign o_push      = accept && i_smp.last_sample;
    assign o_push_data = {run_sum, run_cnt, run_ovf};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref     <= '0;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_started <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            r_ref     <= n_ref;
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
            r_started <= n_started;
            r_ovf     <= n_ovf;
        end
    end

endmodule

FILE: design/cwa_queue.sv
// short register queue of finished run totals between front and back
module cwa_queue #(
    parameter int W     = 41,
    parameter int DEPTH = cwa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [W-1:0]       i_push_data,
    input  logic               i_pop,
    output logic [W-1:0]       o_head,
    output cwa_pkg::t_q_flags  o_flags
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_head        = r_mem[r_rd];
    assign o_flags.full  = (r_count == CNT_W'(DEPTH));
    assign o_flags.empty = (r_count == '0);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

FILE: design/cwa_back.sv
// back end: divides the run total by its count, normalizes and holds the result beat
module cwa_back #(
    parameter int MAX_SAMPLES = cwa_pkg::MAX_SAMPLES_DEF,
    parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
    parameter int SUM_W       = cwa_pkg::ADJ_W + $clog2(MAX_SAMPLES),
    parameter int ENT_W       = SUM_W + CNT_W + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [cwa_pkg::PERIOD_W-1:0]   i_period,
    input  logic [ENT_W-1:0]               i_head,
    input  cwa_pkg::t_q_flags              i_q_flags,
    output logic                           o_pop,
    cwa_out_if.source                      o_avg
);

    localparam int MW = SUM_W + 1;
    localparam int BW = $clog2(SUM_W + 1);

    cwa_pkg::t_back_state r_state, n_state;

    logic                          r_neg, r_ovf;
    logic [SUM_W-1:0]              r_dvd;
    logic [CNT_W-1:0]              r_rem, r_div;
    logic [BW-1:0]                 r_bits;
    logic signed [MW-1:0]          r_mean;
    logic                          r_o_valid;
    logic [cwa_pkg::SAMPLE_W-1:0]  r_o_avg;
    logic                          r_o_ovf;

    logic signed [SUM_W-1:0]       h_sum;
    logic [CNT_W-1:0]              h_cnt;
    logic                          h_ovf;
    logic [CNT_W:0]                rem_sh;
    logic                          q_bit;
    logic signed [MW-1:0]          per_s, mean_s, mean_adj, mean_fin;
    logic                          slot_free, load_out;

    assign h_sum = $signed(i_head[ENT_W-1 -: SUM_W]);
    assign h_cnt = i_head[CNT_W:1];
    assign h_ovf = i_head[0];

    // one quotient bit per cycle, restoring
    assign rem_sh = {r_rem, r_dvd[SUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_div});

    assign per_s    = $signed(MW'(i_period));
    assign mean_s   = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
    assign mean_adj = mean_s[MW-1] ? mean_s + per_s : mean_s;
    assign mean_fin = (r_mean >= per_s) ? r_mean - per_s : r_mean;

    assign slot_free = !r_o_valid || o_avg.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cwa_pkg::BK_IDLE: begin
                if (!i_q_flags.empty) n_state = cwa_pkg::BK_DIV;
            end
            cwa_pkg::BK_DIV: begin
                if (r_bits == BW'(1)) n_state = cwa_pkg::BK_SIGN;
            end
            cwa_pkg::BK_SIGN: begin
                n_state = cwa_pkg::BK_NORM;
            end
            cwa_pkg::BK_NORM: begin
                if (slot_free) n_state = cwa_pkg::BK_IDLE;
            end
            default: begin
                n_state = cwa_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            cwa_pkg::BK_IDLE: o_pop    = !i_q_flags.empty;
            cwa_pkg::BK_NORM: load_out = slot_free;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_neg  <= h_sum[SUM_W-1];
            r_ovf  <= h_ovf;
            r_dvd  <= h_sum[SUM_W-1] ? SUM_W'(-h_sum) : SUM_W'(h_sum);
            r_rem  <= '0;
            r_div  <= h_cnt;
            r_bits <= BW'(SUM_W);
        end else if (r_state == cwa_pkg::BK_DIV) begin
            r_rem  <= q_bit ? CNT_W'(rem_sh - {1'b0, r_div}) : CNT_W'(rem_sh);
            r_dvd  <= {r_dvd[SUM_W-2:0], q_bit};
            r_bits <= r_bits - BW'(1);
        end
        if (r_state == cwa_pkg::BK_SIGN) begin
            r_mean <= mean_adj;
        end
        if (load_out) begin
            r_o_avg <= mean_fin[cwa_pkg::SAMPLE_W-1:0];
            r_o_ovf <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cwa_pkg::BK_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_avg.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_avg.valid      = r_o_valid;
    assign o_avg.average    = r_o_avg;
    assign o_avg.overflowed = r_o_ovf;

    a_div_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cwa_pkg::BK_DIV && $past(r_state) == cwa_pkg::BK_IDLE) |-> $past(o_pop))
        else $error("division started without a queue pop");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cwa_pkg::BK_DIV) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cwa_pkg::BK_DIV) |-> (r_div != '0))
        else $error("zero sample count reached the divider");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cwa_pkg::BK_IDLE) |-> !o_pop)
        else $error("queue popped while back end busy");

endmodule
